### rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned CODE_W = 2;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    PH_REST         = 3'd0,
    PH_PRESS_WAIT   = 3'd1,
    PH_SHORT        = 3'd2,
    PH_LONG         = 3'd3,
    PH_DOUBLE_WAIT  = 3'd4,
    PH_DOUBLE       = 3'd5,
    PH_RELEASE_WAIT = 3'd6
  } phase_t;

  localparam logic [CODE_W-1:0] CODE_NONE   = 2'd0;
  localparam logic [CODE_W-1:0] CODE_SINGLE = 2'd1;
  localparam logic [CODE_W-1:0] CODE_LONG   = 2'd2;
  localparam logic [CODE_W-1:0] CODE_DOUBLE = 2'd3;

  localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [1:0] REG_DOUBLE_GAP  = 2'd2;

  localparam logic [THR_W-1:0] DEBOUNCE_RST   = 16'd10;
  localparam logic [THR_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [THR_W-1:0] DOUBLE_GAP_RST = 16'd300;

  typedef struct packed {
    logic [THR_W-1:0] debounce_ms;
    logic [THR_W-1:0] long_press_ms;
    logic [THR_W-1:0] double_gap_ms;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [CODE_W-1:0] held;
    logic [CODE_W-1:0] held_next;
  } stat_t;

endpackage

`default_nettype wire

### rtl/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// Debounce and classification state machine; advances one step per item.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic                          pin_level,
  input  wire logic [bcc_pkg::TIME_W-1:0]    now_ms,
  input  wire bcc_pkg::cfg_t                 cfg,
  output bcc_pkg::stat_t                     stat
);

  bcc_pkg::phase_t                  phase;
  bcc_pkg::phase_t                  phase_next;
  logic [bcc_pkg::TIME_W-1:0]       change_time;
  logic [bcc_pkg::TIME_W-1:0]       change_time_next;
  logic [bcc_pkg::TIME_W-1:0]       press_start_time;
  logic [bcc_pkg::TIME_W-1:0]       press_start_time_next;
  logic [bcc_pkg::CODE_W-1:0]       held_code;
  logic [bcc_pkg::CODE_W-1:0]       held_code_next;

  logic                             pressed;
  logic [bcc_pkg::TIME_W-1:0]       since_change;
  logic [bcc_pkg::TIME_W-1:0]       since_press;
  logic                             debounce_done;
  logic                             long_done;
  logic                             gap_done;

  assign pressed       = ~pin_level;
  assign since_change  = now_ms - change_time;
  assign since_press   = now_ms - press_start_time;
  assign debounce_done = since_change >= {16'd0, cfg.debounce_ms};
  assign gap_done      = since_change >= {16'd0, cfg.double_gap_ms};
  assign long_done     = since_press  >= {16'd0, cfg.long_press_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= bcc_pkg::PH_REST;
      change_time      <= '0;
      press_start_time <= '0;
      held_code        <= bcc_pkg::CODE_NONE;
    end else if (step) begin
      phase            <= phase_next;
      change_time      <= change_time_next;
      press_start_time <= press_start_time_next;
      held_code        <= held_code_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    change_time_next      = change_time;
    press_start_time_next = press_start_time;
    held_code_next        = held_code;
    case (phase)
      bcc_pkg::PH_PRESS_WAIT: begin
        if (pressed) begin
          if (debounce_done) begin
            phase_next            = bcc_pkg::PH_SHORT;
            press_start_time_next = now_ms;
          end
        end else begin
          phase_next       = bcc_pkg::PH_REST;
          change_time_next = now_ms;
        end
      end
      bcc_pkg::PH_SHORT: begin
        if (pressed) begin
          if (long_done) begin
            phase_next     = bcc_pkg::PH_LONG;
            held_code_next = bcc_pkg::CODE_LONG;
          end
        end else begin
          phase_next       = bcc_pkg::PH_DOUBLE_WAIT;
          change_time_next = now_ms;
        end
      end
      bcc_pkg::PH_LONG, bcc_pkg::PH_DOUBLE: begin
        if (!pressed) begin
          phase_next       = bcc_pkg::PH_RELEASE_WAIT;
          change_time_next = now_ms;
        end
      end
      bcc_pkg::PH_DOUBLE_WAIT: begin
        if (pressed) begin
          if (debounce_done) begin
            phase_next       = bcc_pkg::PH_DOUBLE;
            change_time_next = now_ms;
            held_code_next   = bcc_pkg::CODE_DOUBLE;
          end
        end else if (gap_done) begin
          phase_next     = bcc_pkg::PH_RELEASE_WAIT;
          held_code_next = bcc_pkg::CODE_SINGLE;
        end
      end
      bcc_pkg::PH_RELEASE_WAIT: begin
        if (pressed) begin
          if (held_code == bcc_pkg::CODE_LONG) begin
            phase_next = bcc_pkg::PH_LONG;
          end else if (held_code == bcc_pkg::CODE_DOUBLE) begin
            phase_next = bcc_pkg::PH_DOUBLE;
          end
          change_time_next = now_ms;
        end else if (debounce_done) begin
          phase_next     = bcc_pkg::PH_REST;
          held_code_next = bcc_pkg::CODE_NONE;
        end
      end
      default: begin
        phase_next = bcc_pkg::PH_REST;
        if (pressed) begin
          phase_next       = bcc_pkg::PH_PRESS_WAIT;
          change_time_next = now_ms;
        end
      end
    endcase
  end

  assign stat.phase     = phase;
  assign stat.held      = held_code;
  assign stat.held_next = held_code_next;

endmodule

`default_nettype wire

### rtl/button_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Debounces an active-low button sampled by timestamped polls and reports
// single click, long press and double click codes.
// ----------------------------------------------------------------------------
// Each accepted item is one poll and yields exactly one result item, the
// held click code after that poll, from an output register the next cycle.
// One item is accepted every cycle; the state update (a 32-bit timestamp
// subtract and compare plus the phase logic) completes in the accept cycle,
// and input ready drops only while the output register holds an item that
// has not been taken. Thresholds are written through the APB port at byte
// addresses 0x0 (debounce), 0x4 (long press) and 0x8 (double gap).
`default_nettype none

module button_click_classifier_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bcc_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [bcc_pkg::DATA_W-1:0]         pwdata,
  output logic      [bcc_pkg::DATA_W-1:0]         prdata,
  output logic                                    pready,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               pin_level,
  input  wire logic [bcc_pkg::TIME_W-1:0]         now_ms,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [bcc_pkg::CODE_W-1:0]         click_kind
);

  bcc_pkg::cfg_t  cfg;
  bcc_pkg::stat_t stat;
  logic           wr_en;
  logic [1:0]     reg_idx;
  logic           accept;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bcc_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= bcc_pkg::DEBOUNCE_RST;
      cfg.long_press_ms <= bcc_pkg::LONG_PRESS_RST;
      cfg.double_gap_ms <= bcc_pkg::DOUBLE_GAP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        bcc_pkg::REG_DEBOUNCE:   cfg.debounce_ms   <= pwdata[bcc_pkg::THR_W-1:0];
        bcc_pkg::REG_LONG_PRESS: cfg.long_press_ms <= pwdata[bcc_pkg::THR_W-1:0];
        bcc_pkg::REG_DOUBLE_GAP: cfg.double_gap_ms <= pwdata[bcc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bcc_pkg::REG_DEBOUNCE:   prdata = {16'd0, cfg.debounce_ms};
      bcc_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg.long_press_ms};
      bcc_pkg::REG_DOUBLE_GAP: prdata = {16'd0, cfg.double_gap_ms};
      default:                 prdata = '0;
    endcase
  end

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  bcc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .pin_level (pin_level),
    .now_ms    (now_ms),
    .cfg       (cfg),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      click_kind <= stat.held_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && click_kind == $past(stat.held_next))
    else $error("accepted item did not reach the output register");

  a_long_code: assert property (@(posedge clk) disable iff (rst)
    stat.phase == bcc_pkg::PH_LONG |-> stat.held == bcc_pkg::CODE_LONG)
    else $error("long phase without long press code");

  a_double_code: assert property (@(posedge clk) disable iff (rst)
    stat.phase == bcc_pkg::PH_DOUBLE |-> stat.held == bcc_pkg::CODE_DOUBLE)
    else $error("double phase without double click code");

  a_idle_code: assert property (@(posedge clk) disable iff (rst)
    (stat.phase == bcc_pkg::PH_REST || stat.phase == bcc_pkg::PH_PRESS_WAIT ||
     stat.phase == bcc_pkg::PH_SHORT || stat.phase == bcc_pkg::PH_DOUBLE_WAIT)
    |-> stat.held == bcc_pkg::CODE_NONE)
    else $error("code held outside a reporting phase");
`endif

endmodule

`default_nettype wire

### tb/tb_button_click_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_button_click_classifier_unit
// Self-checking bench for the button click classifier: a directed table of
// polls (single, long and double click, re-press while releasing, timestamp
// wrap) followed by random polls timed around the thresholds, under several
// threshold settings and idle patterns. Every result item is compared with
// its table row's code where typed, else with a cycle-free predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_button_click_classifier_unit;

  typedef struct {
    logic                       pin;
    logic [bcc_pkg::TIME_W-1:0] stamp;
    bit                         typed;
    logic [bcc_pkg::CODE_W-1:0] code;
  } poll_row_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bcc_pkg::ADDR_W-1:0]   paddr;
  logic [bcc_pkg::DATA_W-1:0]   pwdata;
  logic [bcc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid;
  logic                         in_ready;
  logic                         pin_level;
  logic [bcc_pkg::TIME_W-1:0]   now_ms;
  logic                         out_valid;
  logic                         out_ready;
  logic [bcc_pkg::CODE_W-1:0]   click_kind;

  logic                         row_typed;
  logic [bcc_pkg::CODE_W-1:0]   row_code;

  bcc_pkg::cfg_t                cfg;
  bcc_pkg::phase_t              ph;
  logic [bcc_pkg::TIME_W-1:0]   change_at;
  logic [bcc_pkg::TIME_W-1:0]   press_at;
  logic [bcc_pkg::CODE_W-1:0]   held;

  logic [bcc_pkg::CODE_W-1:0]   kind_q[$];
  int                           errors;
  int                           send_idle;
  int                           recv_stall;

  poll_row_t                    dir_rows[27];

  button_click_classifier_unit dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pin_level  (pin_level),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .click_kind (click_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_button_click_classifier_unit: FAIL");
    $finish;
  end

  function automatic bit aged(logic [bcc_pkg::TIME_W-1:0] t,
                              logic [bcc_pkg::TIME_W-1:0] stamp,
                              logic [bcc_pkg::THR_W-1:0] lim);
    logic [bcc_pkg::TIME_W-1:0] d;
    d = t - stamp;
    return d >= {16'd0, lim};
  endfunction

  function automatic logic [bcc_pkg::CODE_W-1:0] classify_poll(logic pin,
                                                               logic [bcc_pkg::TIME_W-1:0] t);
    logic down;
    down = ~pin;
    case (ph)
      bcc_pkg::PH_PRESS_WAIT:
        if (down) begin
          if (aged(t, change_at, cfg.debounce_ms)) begin
            ph = bcc_pkg::PH_SHORT;
            press_at = t;
          end
        end else begin
          ph = bcc_pkg::PH_REST;
          change_at = t;
        end
      bcc_pkg::PH_SHORT:
        if (down) begin
          if (aged(t, press_at, cfg.long_press_ms)) begin
            ph = bcc_pkg::PH_LONG;
            held = bcc_pkg::CODE_LONG;
          end
        end else begin
          ph = bcc_pkg::PH_DOUBLE_WAIT;
          change_at = t;
        end
      bcc_pkg::PH_LONG, bcc_pkg::PH_DOUBLE:
        if (!down) begin
          ph = bcc_pkg::PH_RELEASE_WAIT;
          change_at = t;
        end
      bcc_pkg::PH_DOUBLE_WAIT:
        if (down) begin
          if (aged(t, change_at, cfg.debounce_ms)) begin
            ph = bcc_pkg::PH_DOUBLE;
            change_at = t;
            held = bcc_pkg::CODE_DOUBLE;
          end
        end else if (aged(t, change_at, cfg.double_gap_ms)) begin
          ph = bcc_pkg::PH_RELEASE_WAIT;
          held = bcc_pkg::CODE_SINGLE;
        end
      bcc_pkg::PH_RELEASE_WAIT:
        if (down) begin
          if (held == bcc_pkg::CODE_LONG) ph = bcc_pkg::PH_LONG;
          else if (held == bcc_pkg::CODE_DOUBLE) ph = bcc_pkg::PH_DOUBLE;
          change_at = t;
        end else if (aged(t, change_at, cfg.debounce_ms)) begin
          ph = bcc_pkg::PH_REST;
          held = bcc_pkg::CODE_NONE;
        end
      default: begin
        ph = bcc_pkg::PH_REST;
        if (down) begin
          ph = bcc_pkg::PH_PRESS_WAIT;
          change_at = t;
        end
      end
    endcase
    return held;
  endfunction

  function automatic logic [bcc_pkg::TIME_W-1:0] pick_step();
    int unsigned sel;
    int          d;
    sel = $urandom_range(0, 31);
    if (sel == 0) return $urandom;
    case (sel % 6)
      0:       d = $urandom_range(0, 3);
      1:       d = int'(cfg.debounce_ms) + int'($urandom_range(0, 2)) - 1;
      2:       d = int'(cfg.double_gap_ms) + int'($urandom_range(0, 2)) - 1;
      3:       d = int'(cfg.long_press_ms) + int'($urandom_range(0, 2)) - 1;
      4:       d = $urandom_range(0, cfg.debounce_ms);
      default: d = $urandom_range(0, cfg.double_gap_ms);
    endcase
    if (d < 0) d = 0;
    return d;
  endfunction

  always @(posedge clk) begin
    logic [bcc_pkg::CODE_W-1:0] code;
    logic [bcc_pkg::CODE_W-1:0] want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        code = classify_poll(pin_level, now_ms);
        kind_q.push_back(row_typed ? row_code : code);
      end
      if (out_valid && out_ready) begin
        if (kind_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none actual %0d", $time, click_kind);
        end else begin
          want = kind_q.pop_front();
          if (click_kind !== want) begin
            errors++;
            $display("%0t: click_kind expected %0d actual %0d", $time, want, click_kind);
          end
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic send_poll(logic pin, logic [bcc_pkg::TIME_W-1:0] t, bit typed,
                           logic [bcc_pkg::CODE_W-1:0] code);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= pin;
    now_ms    <= t;
    row_typed <= typed;
    row_code  <= code;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (kind_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [bcc_pkg::THR_W-1:0] val);
    logic [31:0] junk;
    junk    = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:16], val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      bcc_pkg::REG_DEBOUNCE:   cfg.debounce_ms   = val;
      bcc_pkg::REG_LONG_PRESS: cfg.long_press_ms = val;
      bcc_pkg::REG_DOUBLE_GAP: cfg.double_gap_ms = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [bcc_pkg::THR_W-1:0]  deb_set[6];
    logic [bcc_pkg::THR_W-1:0]  long_set[6];
    logic [bcc_pkg::THR_W-1:0]  gap_set[6];
    int                         idle_set[4];
    int                         stall_set[4];
    logic                       pin_now;
    logic [bcc_pkg::TIME_W-1:0] t_now;
    int                         waited;

    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    pin_level  = 1'b1;
    now_ms     = '0;
    row_typed  = 1'b0;
    row_code   = bcc_pkg::CODE_NONE;
    errors     = 0;
    send_idle  = 0;
    recv_stall = 0;
    cfg        = '{bcc_pkg::DEBOUNCE_RST, bcc_pkg::LONG_PRESS_RST, bcc_pkg::DOUBLE_GAP_RST};
    ph         = bcc_pkg::PH_REST;
    change_at  = '0;
    press_at   = '0;
    held       = bcc_pkg::CODE_NONE;

    dir_rows = '{
      '{1'b1, 32'd0,        1'b1, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd100,      1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd110,      1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd150,      1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd450,      1'b1, bcc_pkg::CODE_SINGLE},
      '{1'b1, 32'd455,      1'b1, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd1000,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd1010,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd2010,     1'b1, bcc_pkg::CODE_LONG},
      '{1'b1, 32'd2020,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd2025,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd2030,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd2040,     1'b1, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd3000,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd3010,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd3050,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd3055,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd3060,     1'b1, bcc_pkg::CODE_DOUBLE},
      '{1'b1, 32'd3070,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'd3072,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd3080,     1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd3090,     1'b1, bcc_pkg::CODE_NONE},
      '{1'b0, 32'hFFFF_FFF8, 1'b0, bcc_pkg::CODE_NONE},
      '{1'b0, 32'h0000_0002, 1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd5,        1'b0, bcc_pkg::CODE_NONE},
      '{1'b1, 32'd305,      1'b1, bcc_pkg::CODE_SINGLE},
      '{1'b0, 32'd306,      1'b0, bcc_pkg::CODE_NONE}
    };

    deb_set   = '{16'd3,  16'd0, 16'hFFFF, 16'd1,    16'd10,   16'd0};
    long_set  = '{16'd40, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd0};
    gap_set   = '{16'd20, 16'd0, 16'hFFFF, 16'd0,    16'd300,  16'd0};
    deb_set[5]  = 16'($urandom_range(0, 60));
    long_set[5] = 16'($urandom_range(0, 400));
    gap_set[5]  = 16'($urandom_range(0, 200));
    idle_set  = '{0, 46, 0,  23};
    stall_set = '{0, 0,  46, 23};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      send_poll(dir_rows[i].pin, dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].code);
    drain();

    pin_now = 1'b1;
    foreach (deb_set[s]) begin
      write_reg(bcc_pkg::REG_DEBOUNCE, deb_set[s]);
      write_reg(bcc_pkg::REG_LONG_PRESS, long_set[s]);
      write_reg(bcc_pkg::REG_DOUBLE_GAP, gap_set[s]);
      @(negedge clk);
      t_now = $urandom;
      foreach (idle_set[m]) begin
        send_idle  = idle_set[m];
        recv_stall = stall_set[m];
        repeat (25) begin
          if ($urandom_range(0, 3) == 0) pin_now = ~pin_now;
          t_now = t_now + pick_step();
          send_poll(pin_now, t_now, 1'b0, bcc_pkg::CODE_NONE);
        end
      end
      send_idle  = 0;
      recv_stall = 0;
      drain();
    end

    in_valid <= 1'b0;
    waited = 0;
    while (kind_q.size() != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (kind_q.size() != 0) begin
      errors++;
      $display("%0t: %0d items never arrived", $time, kind_q.size());
    end
    if (errors == 0) $display("tb_button_click_classifier_unit: PASS");
    else $display("tb_button_click_classifier_unit: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
